// File: rtl/qfba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qfba_pkg
// Types, constants and codes shared by the quick-fit block allocator modules.
// ----------------------------------------------------------------------------
package qfba_pkg;

   localparam int NUM_CLASSES      = 4;
   localparam int BLOCKS_PER_CLASS = 8;
   localparam int TOTAL_BLOCKS     = NUM_CLASSES * BLOCKS_PER_CLASS;
   localparam int LIMIT_REGS       = 4;
   // only classes with a limit register can ever be picked
   localparam int USABLE_CLASSES   = (LIMIT_REGS < NUM_CLASSES) ? LIMIT_REGS : NUM_CLASSES;

   localparam int SIZE_W      = 12;
   localparam int HANDLE_W    = 5;
   localparam int CLASS_W     = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int BLK_W       = $clog2(TOTAL_BLOCKS);
   localparam int CLASS_IDX_W = $clog2(NUM_CLASSES);

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 8;
   localparam int RSP_TUSER_W = 2;

   localparam logic [SIZE_W-1:0] CLASS0_LIMIT_RESET = 12'd5;
   localparam logic [SIZE_W-1:0] CLASS1_LIMIT_RESET = 12'd10;
   localparam logic [SIZE_W-1:0] CLASS2_LIMIT_RESET = 12'd20;
   localparam logic [SIZE_W-1:0] CLASS3_LIMIT_RESET = 12'd40;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLASS0_LIMIT = 2'd0,
      CSR_CLASS1_LIMIT = 2'd1,
      CSR_CLASS2_LIMIT = 2'd2,
      CSR_CLASS3_LIMIT = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_IGNORED   = 2'd3
   } status_type;

   typedef logic [LIMIT_REGS-1:0][SIZE_W-1:0] limit_array_type;

   typedef struct packed {
      op_type                operation;
      logic [SIZE_W-1:0]     request_size;
      logic [HANDLE_W-1:0]   block_handle;
      logic                  handle_is_null;
   } req_type;

   typedef struct packed {
      status_type            status;
      logic [HANDLE_W-1:0]   granted_handle;
      logic [CLASS_W-1:0]    size_class;
   } rsp_type;

   typedef struct packed {
      logic                   found;
      logic [CLASS_IDX_W-1:0] cls;
   } pick_type;

   // head pointer or next link, valid clear means null
   typedef struct packed {
      logic             valid;
      logic [BLK_W-1:0] idx;
   } link_type;

endpackage

`default_nettype wire

// File: rtl/qfba_class_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qfba_class_pick
// Maps a request size to the first size class whose limit covers it.
// ----------------------------------------------------------------------------
module qfba_class_pick (
   input  wire logic [qfba_pkg::SIZE_W-1:0] size,
   input  wire qfba_pkg::limit_array_type   limits,
   output qfba_pkg::pick_type               pick
);
   import qfba_pkg::*;

   // scan from the top so the lowest matching class wins
   always_comb begin
      pick = '0;
      for (int c = USABLE_CLASSES - 1; c >= 0; c--) begin
         if (size <= limits[c]) begin
            pick.found = 1'b1;
            pick.cls   = CLASS_IDX_W'(c);
         end
      end
   end

endmodule

`default_nettype wire

// File: rtl/qfba_free_lists.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qfba_free_lists
// Per-class LIFO free lists: head table plus next-link table, one pop or
// push per cycle while go is high, with the result word for the item.
// ----------------------------------------------------------------------------
module qfba_free_lists (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              go,
   input  wire qfba_pkg::req_type req,
   input  wire qfba_pkg::pick_type pick,
   output qfba_pkg::rsp_type      result
);
   import qfba_pkg::*;

   link_type heads_ff [NUM_CLASSES];
   link_type heads_in [NUM_CLASSES];
   link_type links_ff [TOTAL_BLOCKS];
   link_type links_in [TOTAL_BLOCKS];

   link_type         head;
   logic             in_range;
   logic [BLK_W-1:0] hidx;

   assign head     = heads_ff[pick.cls];
   assign in_range = (32'(req.block_handle) < TOTAL_BLOCKS);
   assign hidx     = BLK_W'(req.block_handle);

   always_comb begin
      heads_in = heads_ff;
      links_in = links_ff;
      result   = '{status: STATUS_OK, granted_handle: '0, size_class: '0};
      if (req.operation == OP_ALLOC) begin
         if (!pick.found) begin
            result.status = STATUS_TOO_LARGE;
         end else begin
            result.size_class = CLASS_W'(pick.cls);
            if (!head.valid) begin
               result.status = STATUS_EMPTY;
            end else begin
               result.granted_handle = HANDLE_W'(head.idx);
               heads_in[pick.cls]    = links_ff[head.idx];
            end
         end
      end else begin
         if (req.handle_is_null || !in_range) begin
            result.status = STATUS_IGNORED;
         end else if (!pick.found) begin
            result.status = STATUS_TOO_LARGE;
         end else begin
            result.size_class  = CLASS_W'(pick.cls);
            links_in[hidx]     = head;
            heads_in[pick.cls] = '{valid: 1'b1, idx: hidx};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            heads_ff[c] <= '{valid: 1'b1, idx: BLK_W'(c * BLOCKS_PER_CLASS)};
         end
         // chain every block of a class; the last one of each class is null
         for (int b = 0; b < TOTAL_BLOCKS; b++) begin
            links_ff[b].valid <= ((b % BLOCKS_PER_CLASS) != (BLOCKS_PER_CLASS - 1));
            links_ff[b].idx   <= BLK_W'(b + 1);
         end
      end else if (go) begin
         heads_ff <= heads_in;
         links_ff <= links_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/quick_fit_block_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quick_fit_block_allocator_unit
// Quick-fit allocator over four size classes of fixed blocks.
// ----------------------------------------------------------------------------
// Takes one allocate or free word per cycle while not stalled and returns
// exactly one result word for each, in order. The word is registered in the
// input register, the class pick and the head pop or push on the head and
// next-link register tables are applied as it moves on, and the result is
// registered. Back-pressure on the result side stalls input only when the
// result register is full and not being taken. Reset restores the limits and
// chains all blocks of every class; no clearing pass.
module quick_fit_block_allocator_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // tdata: request_size[11:0], block_handle[16:12], zero[23:17]
   input  wire logic [qfba_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: operation[0], handle_is_null[1]
   input  wire logic [qfba_pkg::REQ_TUSER_W-1:0]  req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: granted_handle[4:0], size_class[6:5], zero[7]
   output logic [qfba_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   // tuser: status[1:0]
   output logic [qfba_pkg::RSP_TUSER_W-1:0]       rsp_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [qfba_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [qfba_pkg::SIZE_W-1:0]       csr_data
);
   import qfba_pkg::*;

   limit_array_type limits_ff;
   req_type         req_hold_ff;
   req_type         req_hold_in;
   logic            req_valid_ff;
   rsp_type         rsp_ff;
   rsp_type         result;
   logic            rsp_valid_ff;
   logic            advance;
   logic            req_take;
   pick_type        pick;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff[CSR_CLASS0_LIMIT] <= CLASS0_LIMIT_RESET;
         limits_ff[CSR_CLASS1_LIMIT] <= CLASS1_LIMIT_RESET;
         limits_ff[CSR_CLASS2_LIMIT] <= CLASS2_LIMIT_RESET;
         limits_ff[CSR_CLASS3_LIMIT] <= CLASS3_LIMIT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CLASS0_LIMIT: limits_ff[CSR_CLASS0_LIMIT] <= csr_data;
            CSR_CLASS1_LIMIT: limits_ff[CSR_CLASS1_LIMIT] <= csr_data;
            CSR_CLASS2_LIMIT: limits_ff[CSR_CLASS2_LIMIT] <= csr_data;
            CSR_CLASS3_LIMIT: limits_ff[CSR_CLASS3_LIMIT] <= csr_data;
            default: ;
         endcase
      end
   end

   // item in the input register moves on when the result register frees up
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      req_hold_in.operation      = op_type'(req_tuser[0]);
      req_hold_in.handle_is_null = req_tuser[1];
      req_hold_in.request_size   = req_tdata[SIZE_W-1:0];
      req_hold_in.block_handle   = req_tdata[SIZE_W+HANDLE_W-1:SIZE_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_hold_ff <= req_hold_in;
      end
   end

   qfba_class_pick u_pick (
      .size   (req_hold_ff.request_size),
      .limits (limits_ff),
      .pick   (pick)
   );

   qfba_free_lists u_lists (
      .clock  (clock),
      .reset  (reset),
      .go     (advance),
      .req    (req_hold_ff),
      .pick   (pick),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {{(RSP_TDATA_W - HANDLE_W - CLASS_W){1'b0}},
                        rsp_ff.size_class, rsp_ff.granted_handle};

`ifndef NO_ASSERTIONS
   a_advance_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result register not loaded after an item advanced");

   a_handle_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STATUS_OK) |-> (rsp_ff.granted_handle == '0))
      else $error("handle granted with a failing status");

   a_no_class_on_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status == STATUS_TOO_LARGE ||
                        rsp_ff.status == STATUS_IGNORED)) |-> (rsp_ff.size_class == '0))
      else $error("size class reported on a rejected word");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quick-fit block allocator unit.
// ----------------------------------------------------------------------------
// Drives allocate and free words into the request stream and keeps a
// cycle-free model of the four free lists and the limit registers. Every
// returned word is compared against the model's reply for the oldest
// accepted request. Runs a short directed sequence on the reset state, drains
// one class to empty, fills the pipe under a long output stall, then walks
// through several limit settings with mostly well-formed random traffic.
// ----------------------------------------------------------------------------
module tb_top;
   import qfba_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 100;

   typedef struct {
      logic [HANDLE_W-1:0] handle;
      int                  cls;
   } held_block_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic [REQ_TUSER_W-1:0]  req_tuser  = '0;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [RSP_TUSER_W-1:0]  rsp_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [SIZE_W-1:0]       csr_data   = '0;

   // allocator model state
   logic [SIZE_W-1:0] limit_model [LIMIT_REGS];
   link_type          head_model  [NUM_CLASSES];
   link_type          link_model  [TOTAL_BLOCKS];

   rsp_type        awaited_replies[$];
   held_block_type held_blocks[$];

   int  mismatches       = 0;
   int  words_sent       = 0;
   int  limit_settings   = 0;
   int  status_seen[4]   = '{0, 0, 0, 0};
   int  cycle_count      = 0;
   int  hold_cycles_left = 0;
   int  stall_left       = 0;
   bit  steady           = 1'b0;

   quick_fit_block_allocator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d replies outstanding",
                  cycle_count, awaited_replies.size());
         $display("Verification failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 15);
   endfunction

   // output side: random stalls plus the long hold-off on request
   always @(posedge clock) begin
      if (hold_cycles_left > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles_left--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady && $urandom_range(99) < 30) stall_left = pick_gap();
      end
   end

   // ---------------------------------------------------------------- model
   task automatic reset_model();
      limit_model[0] = CLASS0_LIMIT_RESET;
      limit_model[1] = CLASS1_LIMIT_RESET;
      limit_model[2] = CLASS2_LIMIT_RESET;
      limit_model[3] = CLASS3_LIMIT_RESET;
      for (int c = 0; c < NUM_CLASSES; c++) begin
         head_model[c] = '{valid: 1'b1, idx: BLK_W'(c * BLOCKS_PER_CLASS)};
         for (int s = 0; s < BLOCKS_PER_CLASS; s++) begin
            if (s + 1 < BLOCKS_PER_CLASS)
               link_model[c * BLOCKS_PER_CLASS + s] =
                  '{valid: 1'b1, idx: BLK_W'(c * BLOCKS_PER_CLASS + s + 1)};
            else
               link_model[c * BLOCKS_PER_CLASS + s] = '{valid: 1'b0, idx: '0};
         end
      end
   endtask

   // first class whose limit covers the size, -1 if none
   function automatic int class_for_size(logic [SIZE_W-1:0] size);
      for (int c = 0; c < USABLE_CLASSES; c++)
         if (size <= limit_model[c]) return c;
      return -1;
   endfunction

   task automatic allocator_step(input req_type rq, output rsp_type rs);
      int               c;
      logic [BLK_W-1:0] b;
      rs = '0;
      rs.status = STATUS_OK;
      if (rq.operation == OP_ALLOC) begin
         c = class_for_size(rq.request_size);
         if (c < 0) begin
            rs.status = STATUS_TOO_LARGE;
         end else begin
            rs.size_class = CLASS_W'(c);
            if (!head_model[c].valid) begin
               rs.status = STATUS_EMPTY;
            end else begin
               b = head_model[c].idx;
               rs.granted_handle = HANDLE_W'(b);
               head_model[c] = link_model[b];
            end
         end
      end else if (rq.handle_is_null || int'(rq.block_handle) >= TOTAL_BLOCKS) begin
         rs.status = STATUS_IGNORED;
      end else begin
         c = class_for_size(rq.request_size);
         if (c < 0) begin
            rs.status = STATUS_TOO_LARGE;
         end else begin
            // no ownership check: pushed onto whatever class the size picks
            rs.size_class = CLASS_W'(c);
            link_model[rq.block_handle] = head_model[c];
            head_model[c] = '{valid: 1'b1, idx: BLK_W'(rq.block_handle)};
         end
      end
   endtask

   // ------------------------------------------------------------ checking
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         status_seen[rsp_tuser]++;
         if (awaited_replies.size() == 0) begin
            $error("unexpected reply word: status %0d tdata 0x%0h", rsp_tuser, rsp_tdata);
            mismatches++;
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_tuser != want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[HANDLE_W-1:0] != want.granted_handle) begin
               $error("granted_handle: expected %0d, actual %0d",
                      want.granted_handle, rsp_tdata[HANDLE_W-1:0]);
               mismatches++;
            end
            if (rsp_tdata[HANDLE_W+CLASS_W-1:HANDLE_W] != want.size_class) begin
               $error("size_class: expected %0d, actual %0d",
                      want.size_class, rsp_tdata[HANDLE_W+CLASS_W-1:HANDLE_W]);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------- driving
   task automatic issue_request(input req_type rq);
      rsp_type rs;
      int      gap;
      req_tdata  <= {{(REQ_TDATA_W-SIZE_W-HANDLE_W){1'b0}}, rq.block_handle, rq.request_size};
      req_tuser  <= {rq.handle_is_null, rq.operation};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      allocator_step(rq, rs);
      awaited_replies.push_back(rs);
      if (rq.operation == OP_ALLOC && rs.status == STATUS_OK)
         held_blocks.push_back('{handle: rs.granted_handle, cls: int'(rs.size_class)});
      words_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
      // pipe is two deep
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input csr_index_type idx, input logic [SIZE_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      limit_model[idx] = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input int l0, input int l1, input int l2, input int l3);
      write_limit(CSR_CLASS0_LIMIT, SIZE_W'(l0));
      write_limit(CSR_CLASS1_LIMIT, SIZE_W'(l1));
      write_limit(CSR_CLASS2_LIMIT, SIZE_W'(l2));
      write_limit(CSR_CLASS3_LIMIT, SIZE_W'(l3));
      limit_settings++;
   endtask

   function automatic req_type make_req(op_type op, int size, int handle, bit is_null);
      req_type rq;
      rq.operation      = op;
      rq.request_size   = SIZE_W'(size);
      rq.block_handle   = HANDLE_W'(handle);
      rq.handle_is_null = is_null;
      return rq;
   endfunction

   // a size that lands in class c, if the current limits allow one
   function automatic logic [SIZE_W-1:0] size_in_class(int c);
      int lo, hi;
      lo = 0;
      hi = int'(limit_model[c]);
      for (int k = 0; k < c; k++)
         if (int'(limit_model[k]) + 1 > lo) lo = int'(limit_model[k]) + 1;
      if (lo > hi) return SIZE_W'($urandom_range(hi, 0));
      if ($urandom_range(3) == 0) return SIZE_W'($urandom_range(1) ? hi : lo);
      return SIZE_W'($urandom_range(hi, lo));
   endfunction

   function automatic logic [SIZE_W-1:0] oversize();
      int top;
      top = 0;
      for (int c = 0; c < USABLE_CLASSES; c++)
         if (int'(limit_model[c]) > top) top = int'(limit_model[c]);
      if (top >= 4095 || $urandom_range(4) == 0) return '1;
      return SIZE_W'($urandom_range(4095, top + 1));
   endfunction

   function automatic req_type random_request();
      req_type rq;
      int      r, pos, c;
      // handle and null bits are don't-care on allocate, randomize them anyway
      rq = make_req(OP_ALLOC, 0, $urandom_range(TOTAL_BLOCKS - 1), 1'($urandom));
      r = $urandom_range(99);
      if (r < 42) begin
         rq.request_size = size_in_class($urandom_range(USABLE_CLASSES - 1));
      end else if (r < 47) begin
         rq.request_size = oversize();
      end else if (r < 80 && held_blocks.size() > 0) begin
         pos = $urandom_range(held_blocks.size() - 1);
         c = held_blocks[pos].cls;
         if ($urandom_range(9) == 0) c = $urandom_range(USABLE_CLASSES - 1);
         rq = make_req(OP_FREE, size_in_class(c), held_blocks[pos].handle, 1'b0);
         held_blocks.delete(pos);
      end else if (r < 92) begin
         // stray or double free
         rq = make_req(OP_FREE, size_in_class($urandom_range(USABLE_CLASSES - 1)),
                       $urandom_range(TOTAL_BLOCKS - 1), $urandom_range(9) == 0);
      end else begin
         rq = make_req(op_type'($urandom_range(1)), $urandom_range(4095),
                       $urandom_range(TOTAL_BLOCKS - 1), 1'($urandom));
      end
      return rq;
   endfunction

   // --------------------------------------------------------------- tests
   task automatic test_reset_state();
      issue_request(make_req(OP_ALLOC, 0, 0, 1'b0));
      issue_request(make_req(OP_ALLOC, 5, 0, 1'b0));
      issue_request(make_req(OP_ALLOC, 6, 0, 1'b0));
      issue_request(make_req(OP_ALLOC, 40, 31, 1'b1));   // null bit ignored on alloc
      issue_request(make_req(OP_ALLOC, 41, 0, 1'b0));
      issue_request(make_req(OP_ALLOC, 4095, 0, 1'b0));
      issue_request(make_req(OP_ALLOC, 20, 0, 1'b0));
      issue_request(make_req(OP_FREE, 0, 31, 1'b1));     // null free
      issue_request(make_req(OP_FREE, 4095, 0, 1'b0));   // free too large
      issue_request(make_req(OP_FREE, 3, 0, 1'b0));
      issue_request(make_req(OP_ALLOC, 1, 0, 1'b0));
      issue_request(make_req(OP_FREE, 15, 8, 1'b0));     // class-1 block onto class 2
      issue_request(make_req(OP_FREE, 15, 8, 1'b0));     // and again
      issue_request(make_req(OP_ALLOC, 15, 0, 1'b0));
      issue_request(make_req(OP_ALLOC, 15, 0, 1'b0));
      drain_replies();
   endtask

   task automatic test_list_exhaust();
      // class 3 already gave out one block
      repeat (BLOCKS_PER_CLASS - 1) issue_request(make_req(OP_ALLOC, 40, 0, 1'b0));
      issue_request(make_req(OP_ALLOC, 21, 0, 1'b0));   // empty list
      issue_request(make_req(OP_FREE, 30, 31, 1'b0));
      issue_request(make_req(OP_ALLOC, 33, 0, 1'b0));
      drain_replies();
   endtask

   task automatic test_output_stall();
      steady = 1'b1;
      hold_cycles_left = 60;
      repeat (20) issue_request(random_request());
      steady = 1'b0;
      drain_replies();
   endtask

   task automatic test_limit_phases();
      int a, b, c;
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: set_limits(CLASS0_LIMIT_RESET, CLASS1_LIMIT_RESET,
                          CLASS2_LIMIT_RESET, CLASS3_LIMIT_RESET);
            1: set_limits(0, 0, 0, 0);
            2: set_limits(4095, 4095, 4095, 4095);
            3: set_limits(0, 1, 2, 4095);
            4: set_limits(3000, 100, 2000, 50);          // out of order
            5: begin
               a = $urandom_range(200);
               b = a + $urandom_range(300);
               c = b + $urandom_range(500);
               set_limits(a, b, c, c + $urandom_range(1000));
            end
            default: set_limits($urandom_range(4095), $urandom_range(4095),
                                $urandom_range(4095), $urandom_range(4095));
         endcase
         steady = (ph == 3);
         repeat (PHASE_ITEMS) issue_request(random_request());
         steady = 1'b0;
         drain_replies();
      end
   endtask

   initial begin
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_list_exhaust();
      test_output_stall();
      test_limit_phases();
      repeat (10) @(posedge clock);
      $display("Sent %0d request words over %0d limit settings",
               words_sent, limit_settings);
      $display("Replies: %0d ok, %0d too large, %0d list empty, %0d ignored",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (mismatches == 0 && awaited_replies.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
